FILE: sv/wsg_pkg.sv
// ---------------------------------------------------------------------------
// wsg_pkg: shared types and constants of the wavetable sample generator
// Widths, register indexes, item kinds and the sine series constants.
// ---------------------------------------------------------------------------
package wsg_pkg;

	localparam int MAX_TABLE     = 4096;
	localparam int FRACTION_BITS = 14;
	localparam int ONE_I         = 1 << FRACTION_BITS;

	localparam int IDX_W    = 12;
	localparam int LEN_W    = 13;
	localparam int SHAPE_W  = 3;
	localparam int SAMPLE_W = 16;
	localparam int QUOT_W   = 33;
	localparam int DVSR_W   = 14;
	localparam int TERMS    = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Configuration register indexes.
	localparam logic REG_WAVE_SHAPE   = 1'b0;
	localparam logic REG_TABLE_LENGTH = 1'b1;

	// Shape codes as written to the shape register.
	localparam logic [SHAPE_W-1:0] SHAPE_BLANK    = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd4;

	// How the back end finishes an item.
	typedef enum logic [2:0] {
		KIND_FIXED  = 3'd0,
		KIND_SINE   = 3'd1,
		KIND_SAW    = 3'd2,
		KIND_TRI_LO = 3'd3,
		KIND_TRI_HI = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                        kind;
		logic signed [SAMPLE_W-1:0]   fixed;
		logic                         oor;
	} side_t;

	// One divider job: initial remainder, bits shifted in, divisor.
	typedef struct packed {
		logic [DVSR_W-1:0] rem;
		logic [QUOT_W-1:0] low;
		logic [DVSR_W-1:0] dvsr;
		side_t             side;
	} job_t;

	// pi/2 in Q30.
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// Factor pairs of the Taylor series and their scaled reciprocals.
	localparam int RECIP_SHIFT = 34;
	localparam logic [6:0] TERM_DIV [TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
	localparam logic [31:0] TERM_RECIP [TERMS] = '{
		32'((64'd1 << RECIP_SHIFT) / 64'd6),
		32'((64'd1 << RECIP_SHIFT) / 64'd20),
		32'((64'd1 << RECIP_SHIFT) / 64'd42),
		32'((64'd1 << RECIP_SHIFT) / 64'd72),
		32'((64'd1 << RECIP_SHIFT) / 64'd110)
	};

endpackage

FILE: sv/wsg_front.sv
// ---------------------------------------------------------------------------
// wsg_front: input stage and classifier
// Holds the configuration registers, registers each index beat and turns it
// into a divider job plus the sideband that tells the back end what to do.
// ---------------------------------------------------------------------------
module wsg_front import wsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	output logic              out_valid,
	input  logic              out_ready,
	output job_t              out_job
);

	logic [SHAPE_W-1:0] shape_q;
	logic [LEN_W-1:0]   length_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [LEN_W-1:0]   n;
	logic [LEN_W-1:0]   half;
	logic [LEN_W-1:0]   last;
	logic               oor;
	logic signed [SAMPLE_W-1:0] square_v;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= SHAPE_BLANK;
			length_q <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVE_SHAPE:   shape_q  <= cfg_wdata[SHAPE_W-1:0];
				REG_TABLE_LENGTH: length_q <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Input register.
	assign s_tready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			idx_s1 <= s_tdata[IDX_W-1:0];
		end
	end

	// Length saturates at the table maximum.
	always_comb begin
		n    = (length_q > LEN_W'(MAX_TABLE)) ? LEN_W'(MAX_TABLE) : length_q;
		half = n >> 1;
		last = n - 13'd1;
		oor  = {1'b0, idx_s1} >= n;
		if (idx_s1 == '0 || {1'b0, idx_s1} == last) begin
			square_v = '0;
		end else if ({1'b0, idx_s1} < half) begin
			square_v = SAMPLE_W'(ONE_I);
		end else begin
			square_v = -SAMPLE_W'(ONE_I);
		end
	end

	// Classification and divider operands.
	always_comb begin
		out_job.rem        = '0;
		out_job.low        = QUOT_W'(idx_s1) << (FRACTION_BITS + 2);
		out_job.low        = out_job.low + QUOT_W'(n);
		out_job.dvsr       = {n, 1'b0};
		out_job.side.kind  = KIND_FIXED;
		out_job.side.fixed = '0;
		out_job.side.oor   = oor;
		if (!oor) begin
			unique case (shape_q)
				SHAPE_SINE: begin
					out_job.side.kind = KIND_SINE;
					out_job.rem       = DVSR_W'(idx_s1);
					out_job.low       = '0;
					out_job.dvsr      = DVSR_W'(n) + 14'd1;
				end
				SHAPE_SQUARE: begin
					out_job.side.fixed = square_v;
				end
				SHAPE_SAW: begin
					out_job.side.kind = KIND_SAW;
				end
				SHAPE_TRIANGLE: begin
					out_job.low = (QUOT_W'(idx_s1) << (FRACTION_BITS + 3)) + QUOT_W'(n);
					out_job.side.kind = ({1'b0, idx_s1} <= half) ? KIND_TRI_LO : KIND_TRI_HI;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/wsg_queue.sv
// ---------------------------------------------------------------------------
// wsg_queue: short job queue
// A four-entry register queue that lets the front and back stall apart.
// ---------------------------------------------------------------------------
module wsg_queue import wsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_job   = mem_q[head_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) tail_q <= tail_q + 1'b1;
			if (pop)  head_q <= head_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= in_job;
		end
	end

endmodule

FILE: sv/wsg_div.sv
// ---------------------------------------------------------------------------
// wsg_div: pipelined restoring divider
// One quotient bit per stage; the sideband travels along with each job.
// ---------------------------------------------------------------------------
module wsg_div import wsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  job_t              in_job,
	output logic              out_valid,
	output logic [QUOT_W-1:0] out_quot,
	output side_t             out_side
);

	logic              v_q    [QUOT_W];
	logic [DVSR_W-1:0] rem_q  [QUOT_W];
	logic [QUOT_W-1:0] low_q  [QUOT_W];
	logic [DVSR_W-1:0] dv_q   [QUOT_W];
	logic [QUOT_W-1:0] quot_q [QUOT_W];
	side_t             side_q [QUOT_W];

	for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
		logic              v_in;
		logic [DVSR_W-1:0] r_in;
		logic [QUOT_W-1:0] l_in;
		logic [DVSR_W-1:0] d_in;
		logic [QUOT_W-1:0] q_in;
		side_t             s_in;
		logic [DVSR_W:0]   trial;
		logic              fits;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = in_job.rem;
			assign l_in = in_job.low;
			assign d_in = in_job.dvsr;
			assign q_in = '0;
			assign s_in = in_job.side;
		end else begin : g_next
			assign v_in = v_q[j-1];
			assign r_in = rem_q[j-1];
			assign l_in = low_q[j-1];
			assign d_in = dv_q[j-1];
			assign q_in = quot_q[j-1];
			assign s_in = side_q[j-1];
		end

		// Shift in the next dividend bit and try to subtract.
		assign trial = {r_in, l_in[QUOT_W-1]};
		assign fits  = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (adv) begin
				v_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[j]  <= fits ? DVSR_W'(trial - {1'b0, d_in}) : trial[DVSR_W-1:0];
				low_q[j]  <= l_in << 1;
				dv_q[j]   <= d_in;
				quot_q[j] <= {q_in[QUOT_W-2:0], fits};
				side_q[j] <= s_in;
			end
		end
	end

	assign out_valid = v_q[QUOT_W-1];
	assign out_quot  = quot_q[QUOT_W-1];
	assign out_side  = side_q[QUOT_W-1];

endmodule

FILE: sv/wsg_back.sv
// ---------------------------------------------------------------------------
// wsg_back: sample execution pipeline
// Divides, finishes the linear shapes, runs the sine series one term per
// three stages and holds the result in the output register.
// ---------------------------------------------------------------------------
module wsg_back import wsg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  job_t                in_job,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,
	output logic                m_tuser
);

	logic              adv;
	logic              dv_valid;
	logic [QUOT_W-1:0] dv_quot;
	side_t             dv_side;

	logic              vld_s1;
	logic [30:0]       r_s1;
	logic              neg_s1;
	side_t             side_s1;
	logic              vld_s2;
	logic [30:0]       x_s2;
	logic              neg_s2;
	side_t             side_s2;
	logic              vld_s3;
	logic [31:0]       x2_s3;
	logic [32:0]       t_s3;
	logic [33:0]       sum_s3;
	logic              neg_s3;
	side_t             side_s3;

	logic        av_q [TERMS];
	logic [32:0] aa_q [TERMS];
	logic [31:0] ax2_q [TERMS];
	logic [33:0] asum_q [TERMS];
	logic        aneg_q [TERMS];
	side_t       aside_q [TERMS];
	logic        bv_q [TERMS];
	logic [32:0] ba_q [TERMS];
	logic [32:0] bq0_q [TERMS];
	logic [31:0] bx2_q [TERMS];
	logic [33:0] bsum_q [TERMS];
	logic        bneg_q [TERMS];
	side_t       bside_q [TERMS];
	logic        cv_q [TERMS];
	logic [32:0] ct_q [TERMS];
	logic [31:0] cx2_q [TERMS];
	logic [33:0] csum_q [TERMS];
	logic        cneg_q [TERMS];
	side_t       cside_q [TERMS];

	logic [33:0]          p1;
	logic [29:0]          r_low;
	logic signed [18:0]   lin;
	side_t                side_fin1;
	logic [61:0]          xprod;
	logic [61:0]          x2prod;
	logic [34:0]          mag;
	logic signed [SAMPLE_W-1:0] sine_v;
	logic signed [SAMPLE_W-1:0] fin_v;
	logic                 vld_out_q;
	logic [SAMPLE_W-1:0]  data_out_q;
	logic                 oor_out_q;

	// The whole pipeline moves when the output register can take a beat.
	assign adv      = !vld_out_q || m_tready;
	assign in_ready = adv;

	wsg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_job    (in_job),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// Stage 1: phase to quadrant and mirrored residue; finish saw and triangle.
	always_comb begin
		p1        = (34'(dv_quot) + 34'd1) >> 1;
		r_low     = p1[29:0];
		side_fin1 = dv_side;
		lin       = '0;
		case (dv_side.kind)
			KIND_SAW:    lin = 19'(ONE_I) - $signed({2'b0, dv_quot[16:0]});
			KIND_TRI_LO: lin = $signed({2'b0, dv_quot[16:0]}) - 19'(ONE_I);
			KIND_TRI_HI: lin = 19'(3 * ONE_I) - $signed({2'b0, dv_quot[16:0]});
			default:     lin = '0;
		endcase
		if (dv_side.kind == KIND_SAW || dv_side.kind == KIND_TRI_LO ||
		    dv_side.kind == KIND_TRI_HI) begin
			side_fin1.kind  = KIND_FIXED;
			side_fin1.fixed = lin[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= dv_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign xprod  = 62'(r_s1) * 62'(HALF_PI_Q30) + (62'd1 << 29);
	assign x2prod = 62'(x_s2) * 62'(x_s2);

	// Stages 1 to 3: residue, angle in Q30, angle squared.
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1    <= p1[30] ? (31'd1 << 30) - 31'(r_low) : 31'(r_low);
			neg_s1  <= p1[31];
			side_s1 <= side_fin1;
			x_s2    <= xprod[60:30];
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			x2_s3   <= x2prod[61:30];
			t_s3    <= 33'(x_s2);
			sum_s3  <= 34'(x_s2);
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	// Series terms: multiply by x^2, scale by reciprocal, correct and add or subtract in turn.
	for (genvar j = 0; j < TERMS; j++) begin : g_term
		logic        v_in;
		logic [32:0] t_in;
		logic [31:0] x2_in;
		logic [33:0] sum_in;
		logic        neg_in;
		side_t       side_in;
		logic [64:0] tprod;
		logic [64:0] rprod;
		logic [39:0] qd;
		logic [39:0] rem;
		logic [32:0] qt;

		if (j == 0) begin : g_first
			assign v_in    = vld_s3;
			assign t_in    = t_s3;
			assign x2_in   = x2_s3;
			assign sum_in  = sum_s3;
			assign neg_in  = neg_s3;
			assign side_in = side_s3;
		end else begin : g_next
			assign v_in    = cv_q[j-1];
			assign t_in    = ct_q[j-1];
			assign x2_in   = cx2_q[j-1];
			assign sum_in  = csum_q[j-1];
			assign neg_in  = cneg_q[j-1];
			assign side_in = cside_q[j-1];
		end

		assign tprod = 65'(t_in) * 65'(x2_in);
		assign rprod = 65'(aa_q[j]) * 65'(TERM_RECIP[j]);
		assign qd    = 40'(bq0_q[j]) * 40'(TERM_DIV[j]);
		assign rem   = 40'(ba_q[j]) - qd;
		assign qt    = bq0_q[j] + 33'(rem >= 40'(TERM_DIV[j]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av_q[j] <= 1'b0;
				bv_q[j] <= 1'b0;
				cv_q[j] <= 1'b0;
			end else if (adv) begin
				av_q[j] <= v_in;
				bv_q[j] <= av_q[j];
				cv_q[j] <= bv_q[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				aa_q[j]    <= tprod[62:30];
				ax2_q[j]   <= x2_in;
				asum_q[j]  <= sum_in;
				aneg_q[j]  <= neg_in;
				aside_q[j] <= side_in;
				ba_q[j]    <= aa_q[j];
				bq0_q[j]   <= 33'(rprod[64:RECIP_SHIFT]);
				bx2_q[j]   <= ax2_q[j];
				bsum_q[j]  <= asum_q[j];
				bneg_q[j]  <= aneg_q[j];
				bside_q[j] <= aside_q[j];
				ct_q[j]    <= qt;
				cx2_q[j]   <= bx2_q[j];
				csum_q[j]  <= (j % 2 == 1) ? bsum_q[j] + 34'(qt) : bsum_q[j] - 34'(qt);
				cneg_q[j]  <= bneg_q[j];
				cside_q[j] <= bside_q[j];
			end
		end
	end

	// Round the series to the sample format, cap at one and apply the sign; other kinds take the fixed value.
	always_comb begin
		mag = ((35'({csum_q[TERMS-1], 1'b0}) >> (30 - FRACTION_BITS)) + 35'd1) >> 1;
		if (mag > 35'(ONE_I)) begin
			mag = 35'(ONE_I);
		end
		sine_v = cneg_q[TERMS-1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
		fin_v  = (cside_q[TERMS-1].kind == KIND_SINE) ? sine_v : cside_q[TERMS-1].fixed;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_out_q <= cv_q[TERMS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_out_q <= fin_v;
			oor_out_q  <= cside_q[TERMS-1].oor;
		end
	end

	assign m_tvalid = vld_out_q;
	assign m_tdata  = data_out_q;
	assign m_tuser  = oor_out_q;

`ifndef NO_ASSERTIONS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out_q && oor_out_q |-> data_out_q == '0)
		else $error("out-of-range sample is not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_out_q |-> ($signed(data_out_q) <= 16'sd16384 &&
		               $signed(data_out_q) >= -16'sd16384))
		else $error("sample outside plus or minus one");

	a_series_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cv_q[TERMS-1] |-> csum_q[TERMS-1][33:31] == 3'b000)
		else $error("sine series sum wrapped");

	a_oor_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		cv_q[TERMS-1] && cside_q[TERMS-1].oor |-> cside_q[TERMS-1].kind == KIND_FIXED)
		else $error("out-of-range item took a computed path");
`endif

endmodule

FILE: sv/wavetable_sample_generator.sv
// ---------------------------------------------------------------------------
// wavetable_sample_generator: one waveform table sample per index
// Blank, sine, square, saw and triangle tables of configurable length,
// samples in signed Q2.14.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  s_axis  | in        | tdata[11:0] sample_index
//  m_axis  | out       | tdata[15:0] sample_value, tuser index_out_of_range
//  cfg     | in        | index 0 wave_shape, index 1 table_length
//
// One beat in and one beat out per cycle in steady state, while m_tready stays high.
// A beat passes the input register, the queue, 33 divider stages (one quotient
// bit each), 18 sine stages and the output register.
// Reset clears the shape to blank and the length to 256 and empties the pipe.
// A stall on the output freezes the back pipeline; the queue absorbs up to
// four beats and the input register one more before s_tready deasserts.
module wavetable_sample_generator import wsg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [LEN_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [11:0] sample_index, [15:12] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_value
	output logic                m_tuser    // [0] index_out_of_range
);

	logic fr_valid;
	logic fr_ready;
	job_t fr_job;
	logic qu_valid;
	logic qu_ready;
	job_t qu_job;

	wsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_job   (fr_job)
	);

	wsg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_job    (fr_job),
		.out_valid (qu_valid),
		.out_ready (qu_ready),
		.out_job   (qu_job)
	);

	wsg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qu_valid),
		.in_ready (qu_ready),
		.in_job   (qu_job),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: test/wavetable_sample_generator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wavetable_sample_generator_test: self-checking bench for the sample generator
// Drives table indexes over the input stream under every shape and a range of
// table lengths, predicts each sample in fixed point and compares it with the
// output stream. Input bursts and output stalls are random.
// ---------------------------------------------------------------------------
module wavetable_sample_generator_test import wsg_pkg::*; ();

	localparam int PIPE_LATENCY = 54;
	localparam int STALL_LIMIT  = 20000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [LEN_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [SAMPLE_W-1:0] m_tdata;
	logic                m_tuser;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                oor;
	} sample_t;

	sample_t          pending_samples[$];
	logic [SHAPE_W-1:0] cur_shape;
	logic [LEN_W-1:0]   cur_length;
	int               mismatch_count;
	int               idle_cycles;
	bit               timed_out;
	int               burst_left;

	wavetable_sample_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sine magnitude by a Taylor series in Q30, sign by quadrant.
	function automatic longint sine_q(longint unsigned i, longint unsigned n);
		longint unsigned p, quad, r, x, x2, t, sum, mag;
		longint unsigned divs[5];
		divs = '{6, 20, 42, 72, 110};
		p = (((i << 33) / (n + 1)) + 1) >> 1;
		quad = (p >> 30) & 3;
		r = p & ((64'd1 << 30) - 1);
		if (quad[0]) r = (64'd1 << 30) - r;
		x = (r * 64'd1686629713 + (64'd1 << 29)) >> 30;
		x2 = (x * x) >> 30;
		t = x;
		sum = x;
		for (int k = 0; k < 5; k++) begin
			t = ((t * x2) >> 30) / divs[k];
			if (k % 2 == 1) sum += t;
			else sum -= t;
		end
		mag = (((sum << 1) >> (30 - FRACTION_BITS)) + 1) >> 1;
		if (mag > ONE_I) mag = ONE_I;
		return (quad >= 2) ? -longint'(mag) : longint'(mag);
	endfunction

	// Expected sample for one index under the current shape and length.
	function automatic sample_t table_sample(logic [IDX_W-1:0] idx);
		longint unsigned i, n, ratio;
		longint v;
		sample_t s;
		i = idx;
		n = cur_length;
		v = 0;
		if (n > MAX_TABLE) n = MAX_TABLE;
		s.oor = (i >= n);
		if (!s.oor) begin
			case (cur_shape)
				SHAPE_SINE: v = sine_q(i, n);
				SHAPE_SQUARE: begin
					if (i == 0 || i == n - 1) v = 0;
					else v = (i < n / 2) ? ONE_I : -ONE_I;
				end
				SHAPE_SAW: begin
					ratio = (4 * i * ONE_I + n) / (2 * n);
					v = ONE_I - longint'(ratio);
				end
				SHAPE_TRIANGLE: begin
					ratio = (8 * i * ONE_I + n) / (2 * n);
					if (i <= n / 2) v = -ONE_I + longint'(ratio);
					else v = 3 * ONE_I - longint'(ratio);
				end
				default: v = 0;
			endcase
		end
		s.value = v[SAMPLE_W-1:0];
		return s;
	endfunction

	// Send one index beat; the sender mostly pauses between bursts of random length.
	// Valid stays high after the handshake so that bursts run back to back.
	task automatic send_index(input logic [IDX_W-1:0] idx);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, idx};
		pending_samples.push_back(table_sample(idx));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Wait for the pipe to drain, then write both registers.
	task automatic set_table(input logic [SHAPE_W-1:0] shape, input logic [LEN_W-1:0] len);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0 && !timed_out) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WAVE_SHAPE;
		cfg_wdata <= LEN_W'(shape);
		@(posedge clk);
		cfg_index <= REG_TABLE_LENGTH;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_shape  = shape;
		cur_length = len;
	endtask

	// Output check: compare each beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: value %0h oor %0b", m_tdata, m_tuser);
			end else begin
				sample_t want;
				want = pending_samples.pop_front();
				if (want.value !== m_tdata || want.oor !== m_tuser) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("sample mismatch: expected %0h/%0b actual %0h/%0b",
							want.value, want.oor, m_tdata, m_tuser);
				end
			end
		end
	end

	// Receiver stalls at random, with ready drawn anew on every clock and mostly high.
	always @(posedge clk) begin
		int phase;
		phase = $urandom_range(0, 15);
		if (!arst_n) m_tready <= 1'b1;
		else m_tready <= (phase < 11) || ($urandom_range(0, 63) == 0);
	end

	// Watchdog on cycles with no accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("** wavetable_sample_generator: FAILED **");
			$finish;
		end
	end

	// Reset values: blank shape and length 256, indexes at and beyond the table edge.
	task automatic test_reset_defaults();
		cur_shape  = SHAPE_BLANK;
		cur_length = 13'd256;
		send_index(12'd0);
		send_index(12'd255);
		send_index(12'd256);
		send_index(12'hFFF);
	endtask

	task automatic test_directed_shapes();
		logic [SHAPE_W-1:0] shapes[5];
		shapes = '{SHAPE_SINE, SHAPE_SQUARE, SHAPE_SAW, SHAPE_TRIANGLE, SHAPE_BLANK};
		foreach (shapes[k]) begin
			set_table(shapes[k], 13'd4096);
			send_index(12'd0);
			send_index(12'd2048);
			send_index(12'd4095);
		end
		// Length of zero, of one, above the maximum and an unknown shape.
		set_table(SHAPE_SAW, 13'd0);
		send_index(12'd0);
		set_table(SHAPE_TRIANGLE, 13'd1);
		send_index(12'd0);
		send_index(12'd1);
		set_table(SHAPE_SQUARE, 13'h1FFF);
		send_index(12'd4095);
		set_table(3'd7, 13'd2);
		send_index(12'd1);
		send_index(12'd2);
	endtask

	task automatic test_random_tables();
		logic [LEN_W-1:0] len;
		for (int ph = 0; ph < 30; ph++) begin
			case ($urandom_range(0, 5))
				0: len = LEN_W'($urandom_range(0, 3));
				1: len = LEN_W'($urandom_range(4096, 8191));
				2: len = 13'd4096;
				default: len = LEN_W'($urandom_range(2, 4096));
			endcase
			set_table(SHAPE_W'($urandom_range(0, 7)), len);
			repeat (50) begin
				if ($urandom_range(0, 4) == 0 || len < 2) send_index(IDX_W'($urandom));
				else send_index(IDX_W'($urandom_range(0, (len > 4096 ? 4096 : len) - 1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WAVE_SHAPE;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		burst_left = 0;
		cur_shape = SHAPE_BLANK;
		cur_length = 13'd256;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_shapes();
		test_random_tables();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && pending_samples.size() == 0)
			$display("** wavetable_sample_generator: PASSED **");
		else
			$display("** wavetable_sample_generator: FAILED **");
		$finish;
	end

endmodule
